### sv/iso8601_timestamp_to_epoch_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the timestamp-to-epoch converter
// Assertions are compiled only in simulation. Under synthesis the macros
// expand to nothing.
// ----------------------------------------------------------------------------
`ifndef ISO8601_TIMESTAMP_TO_EPOCH_ASSERT_SVH
`define ISO8601_TIMESTAMP_TO_EPOCH_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define ISOTS_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define ISOTS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define ISOTS_ASSERT_NOW(lbl, ante, cons, msg)
`define ISOTS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### sv/isots_pkg.sv
// ----------------------------------------------------------------------------
// isots_pkg
// Types, character codes and arithmetic constants shared by the converter.
// ----------------------------------------------------------------------------
package isots_pkg;

   localparam int CH_W    = 8;
   localparam int EPOCH_W = 39;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_DASH  = 8'h2D;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_T     = 8'h54;
   localparam logic [7:0] CH_Z     = 8'h5A;
   localparam logic [7:0] CH_PLUS  = 8'h2B;

   // floor(x/12) = (x*43)>>9 for x <= 110
   localparam int MONTH_ROUND  = 11;
   localparam int DIV12_MUL    = 43;
   localparam int DIV12_SHIFT  = 9;
   // floor(x/400) = (x*10486)>>22 for x < 16384
   localparam int DIV400_MUL   = 10486;
   localparam int DIV400_SHIFT = 22;
   // floor(x/100) = (x*41)>>12 for x < 400
   localparam int DIV100_MUL   = 41;
   localparam int DIV100_SHIFT = 12;

   localparam int YEAR_BIAS      = 400;
   localparam int DAYS_PER_YEAR  = 365;
   localparam int DAYS_PER_ERA   = 146097;
   // civil day offset plus one era for the biased year
   localparam int EPOCH_DAY_BIAS = 865565;
   localparam int SEC_PER_DAY    = 86400;
   localparam int SEC_PER_HOUR   = 3600;
   localparam int SEC_PER_MIN    = 60;

   typedef enum logic [4:0] {
      POS_Y0, POS_Y1, POS_Y2, POS_Y3, POS_AFTER_YEAR,
      POS_MON0, POS_MON1, POS_AFTER_MON,
      POS_DAY0, POS_DAY1, POS_T,
      POS_HR0, POS_HR1, POS_AFTER_HR,
      POS_MIN0, POS_MIN1, POS_AFTER_MIN, POS_AFTER_COLON,
      POS_SEC1, POS_ZONE,
      POS_ZH0, POS_ZH1, POS_AFTER_ZH, POS_ZM0, POS_ZM1, POS_END
   } pos_type;

   typedef enum logic [3:0] {
      PH_PARSE, PH_C1, PH_C2, PH_C3, PH_C4, PH_C5, PH_C6, PH_C7, PH_C8, PH_LOAD
   } phase_type;

   typedef enum logic [3:0] {
      STEP_NONE, STEP_1, STEP_2, STEP_3, STEP_4, STEP_5, STEP_6, STEP_7, STEP_8
   } step_type;

   typedef enum logic [3:0] {
      ACC_NONE, ACC_YEAR, ACC_MONTH, ACC_DAY, ACC_HOUR, ACC_MINUTE, ACC_SECOND,
      ACC_ZH, ACC_ZM
   } acc_type;

   typedef struct packed {
      acc_type  acc;
      logic     push;       // 1: acc*10+d, 0: load d
      logic     zone_set;
      logic     zone_neg;
      step_type step;
      logic     out_load;
      logic     out_ok;
      logic     clear;
   } dp_cmd_type;

   typedef struct packed {
      logic is_nul;
      logic is_digit;
      logic is_dash;
      logic is_colon;
      logic is_t;
      logic is_z;
      logic is_plus;
   } dp_stat_type;

   // day of a March-based year on which month m0 (0 = January) starts
   function automatic logic [8:0] doy_of_month(logic [3:0] m0);
      logic [8:0] doy;
      unique case (m0)
         4'd0:    doy = 9'd306;
         4'd1:    doy = 9'd337;
         4'd2:    doy = 9'd0;
         4'd3:    doy = 9'd31;
         4'd4:    doy = 9'd61;
         4'd5:    doy = 9'd92;
         4'd6:    doy = 9'd122;
         4'd7:    doy = 9'd153;
         4'd8:    doy = 9'd184;
         4'd9:    doy = 9'd214;
         4'd10:   doy = 9'd245;
         4'd11:   doy = 9'd275;
         default: doy = 9'd0;
      endcase
      return doy;
   endfunction

endpackage

### sv/iso8601_timestamp_to_epoch.sv
// ----------------------------------------------------------------------------
// iso8601_timestamp_to_epoch
// Parses an ISO 8601 timestamp (YYYY[-]MM[-]DDThh[:]mm[:][ss] then Z or
// +/-hh[:]mm), one character per item, and on the zero-byte terminator
// returns ok and signed UTC seconds since 1970 (0 when the text does not
// match). Out-of-range fields carry over as in timegm. Characters are taken
// one per cycle outside a conversion. A terminator stalls the input for
// the conversion: eight steps through the date datapath, then a load of
// the output register, and the next character can be accepted in the
// cycle in which the result is presented. The conversion waits only if
// the previous result is still held in the output register.
// ----------------------------------------------------------------------------
`include "iso8601_timestamp_to_epoch_assert.svh"

module iso8601_timestamp_to_epoch (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [isots_pkg::CH_W-1:0]           req_ch,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_ok,
   output logic signed [isots_pkg::EPOCH_W-1:0] rsp_epoch_seconds
);
   import isots_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   isots_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   isots_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_ch            (req_ch),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_ok            (rsp_ok),
      .rsp_epoch_seconds (rsp_epoch_seconds)
   );

   `ISOTS_ASSERT_NOW(a_fail_zero, rsp_valid && !rsp_ok, rsp_epoch_seconds == '0, "failed item carries nonzero seconds")
   `ISOTS_ASSERT_NEXT(a_term_stalls, req_valid && !req_stall && (req_ch == CH_NUL), req_stall, "input not stalled during conversion")
   `ISOTS_ASSERT_NEXT(a_load_valid, cmd.out_load, rsp_valid, "loaded result not presented")
   `ISOTS_ASSERT_NOW(a_load_free, cmd.out_load, !rsp_valid || !rsp_stall, "result register overwritten while held")

endmodule

### sv/isots_dp.sv
// ----------------------------------------------------------------------------
// isots_dp
// Field accumulators, character classifier and the stepped date-to-seconds
// datapath, with the result register.
// ----------------------------------------------------------------------------
module isots_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [isots_pkg::CH_W-1:0]           req_ch,
   input  isots_pkg::dp_cmd_type                cmd,
   output isots_pkg::dp_stat_type               stat,
   output logic                                 rsp_ok,
   output logic signed [isots_pkg::EPOCH_W-1:0] rsp_epoch_seconds
);
   import isots_pkg::*;

   function automatic logic [6:0] push7(logic [6:0] acc, logic [3:0] d);
      logic [10:0] tmp;
      tmp = 11'(acc) * 11'd10 + 11'(d);
      return tmp[6:0];
   endfunction

   logic [3:0]  digit;
   logic [17:0] year_push;

   logic [13:0] year_ff;
   logic [6:0]  month_ff, day_ff, hour_ff, minute_ff, second_ff, zh_ff, zm_ff;
   logic        zone_neg_ff;

   // conversion registers
   logic [13:0] y_ff, y_in;
   logic [3:0]  m0_ff, m0_in;
   logic [18:0] hsec_ff, hsec_in, zsec_ff, zsec_in;
   logic [4:0]  era_ff, era_in;
   logic [18:0] tod_ff, tod_in, zone_ff, zone_in;
   logic [8:0]  yoe_ff, yoe_in;
   logic [17:0] yoe365_ff, yoe365_in;
   logic [1:0]  c100_ff, c100_in;
   logic [21:0] era_days_ff, era_days_in;
   logic [17:0] doe_ff, doe_in;
   logic [23:0] days_ff, days_in;
   logic [EPOCH_W-1:0] dsec_ff, dsec_in, secs_ff, secs_in;
   logic        rsp_ok_ff;
   logic [EPOCH_W-1:0] rsp_epoch_ff;

   logic [7:0]  t8;
   logic [13:0] q12_prod;
   logic [3:0]  q12, r12;
   logic [27:0] era_prod;
   logic [13:0] c100_prod;
   logic signed [41:0] day_sec_prod;

   assign digit = 4'(req_ch - CH_ZERO);
   assign year_push = 18'(year_ff) * 18'd10 + 18'(digit);

   always_comb begin
      stat.is_nul   = (req_ch == CH_NUL);
      stat.is_digit = (req_ch >= CH_ZERO) && (req_ch <= CH_NINE);
      stat.is_dash  = (req_ch == CH_DASH);
      stat.is_colon = (req_ch == CH_COLON);
      stat.is_t     = (req_ch == CH_T);
      stat.is_z     = (req_ch == CH_Z);
      stat.is_plus  = (req_ch == CH_PLUS);
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         year_ff     <= '0;
         month_ff    <= '0;
         day_ff      <= '0;
         hour_ff     <= '0;
         minute_ff   <= '0;
         second_ff   <= '0;
         zh_ff       <= '0;
         zm_ff       <= '0;
         zone_neg_ff <= 1'b0;
      end else begin
         unique case (cmd.acc)
            ACC_NONE:   ;
            ACC_YEAR:   year_ff   <= year_push[13:0];
            ACC_MONTH:  month_ff  <= cmd.push ? push7(month_ff, digit)  : 7'(digit);
            ACC_DAY:    day_ff    <= cmd.push ? push7(day_ff, digit)    : 7'(digit);
            ACC_HOUR:   hour_ff   <= cmd.push ? push7(hour_ff, digit)   : 7'(digit);
            ACC_MINUTE: minute_ff <= cmd.push ? push7(minute_ff, digit) : 7'(digit);
            ACC_SECOND: second_ff <= cmd.push ? push7(second_ff, digit) : 7'(digit);
            ACC_ZH:     zh_ff     <= cmd.push ? push7(zh_ff, digit)     : 7'(digit);
            ACC_ZM:     zm_ff     <= cmd.push ? push7(zm_ff, digit)     : 7'(digit);
            default:    ;
         endcase
         if (cmd.zone_set) begin
            zone_neg_ff <= cmd.zone_neg;
         end
      end
   end

   always_comb begin
      // step 1: month carry into the year, March-based year, time of day and zone
      t8       = 8'(month_ff) + 8'(MONTH_ROUND);
      q12_prod = 14'(t8) * 14'(DIV12_MUL);
      q12      = 4'(q12_prod >> DIV12_SHIFT);
      r12      = 4'(t8 - 8'(q12) * 8'd12);
      m0_in    = r12;
      y_in     = 14'(year_ff) + 14'(q12) + 14'(YEAR_BIAS - 1) - 14'(r12 <= 4'd1);
      hsec_in  = 19'(hour_ff) * 19'(SEC_PER_HOUR);
      zsec_in  = 19'(zh_ff) * 19'(SEC_PER_HOUR);
      // step 2
      era_prod = 28'(y_ff) * 28'(DIV400_MUL);
      era_in   = 5'(era_prod >> DIV400_SHIFT);
      tod_in   = hsec_ff + 19'(minute_ff) * 19'(SEC_PER_MIN) + 19'(second_ff);
      zone_in  = zsec_ff + 19'(zm_ff) * 19'(SEC_PER_MIN);
      // step 3
      yoe_in   = 9'(y_ff - 14'(era_ff) * 14'(YEAR_BIAS));
      // step 4
      yoe365_in   = 18'(yoe_ff) * 18'(DAYS_PER_YEAR);
      c100_prod   = 14'(yoe_ff) * 14'(DIV100_MUL);
      c100_in     = 2'(c100_prod >> DIV100_SHIFT);
      era_days_in = 22'(era_ff) * 22'(DAYS_PER_ERA);
      // step 5
      doe_in   = yoe365_ff + 18'(yoe_ff >> 2) - 18'(c100_ff) + 18'(doy_of_month(m0_ff));
      // step 6: wraps to two's complement
      days_in  = 24'(era_days_ff) + 24'(doe_ff) + 24'(day_ff) - 24'(EPOCH_DAY_BIAS + 1);
      // step 7
      day_sec_prod = $signed(days_ff) * $signed(18'(SEC_PER_DAY));
      dsec_in  = EPOCH_W'(day_sec_prod);
      // step 8: '+' zone subtracts, '-' zone adds
      if (zone_neg_ff) begin
         secs_in = dsec_ff + EPOCH_W'(tod_ff) + EPOCH_W'(zone_ff);
      end else begin
         secs_in = dsec_ff + EPOCH_W'(tod_ff) - EPOCH_W'(zone_ff);
      end
   end

   always_ff @(posedge clock) begin
      unique case (cmd.step)
         STEP_NONE: ;
         STEP_1: begin
            y_ff    <= y_in;
            m0_ff   <= m0_in;
            hsec_ff <= hsec_in;
            zsec_ff <= zsec_in;
         end
         STEP_2: begin
            era_ff  <= era_in;
            tod_ff  <= tod_in;
            zone_ff <= zone_in;
         end
         STEP_3: yoe_ff <= yoe_in;
         STEP_4: begin
            yoe365_ff   <= yoe365_in;
            c100_ff     <= c100_in;
            era_days_ff <= era_days_in;
         end
         STEP_5: doe_ff  <= doe_in;
         STEP_6: days_ff <= days_in;
         STEP_7: dsec_ff <= dsec_in;
         STEP_8: secs_ff <= secs_in;
         default: ;
      endcase
      if (cmd.out_load) begin
         rsp_ok_ff    <= cmd.out_ok;
         rsp_epoch_ff <= cmd.out_ok ? secs_ff : '0;
      end
   end

   assign rsp_ok            = rsp_ok_ff;
   assign rsp_epoch_seconds = $signed(rsp_epoch_ff);

endmodule

### sv/isots_ctrl.sv
// ----------------------------------------------------------------------------
// isots_ctrl
// Grammar state machine, handshake control and conversion sequencer.
// ----------------------------------------------------------------------------
module isots_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  isots_pkg::dp_stat_type stat,
   output isots_pkg::dp_cmd_type  cmd
);
   import isots_pkg::*;

   phase_type phase_ff, phase_in;
   pos_type   pos_ff, pos_in;
   logic      failed_ff, failed_in;
   logic      ok_ff, ok_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_PARSE;
         pos_ff       <= POS_Y0;
         failed_ff    <= 1'b0;
         ok_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         failed_ff    <= failed_in;
         ok_ff        <= ok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      pos_type nxt;
      logic    bad;

      phase_in     = phase_ff;
      pos_in       = pos_ff;
      failed_in    = failed_ff;
      ok_in        = ok_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      nxt          = POS_END;
      bad          = 1'b0;

      cmd.acc      = ACC_NONE;
      cmd.push     = 1'b0;
      cmd.zone_set = 1'b0;
      cmd.zone_neg = !stat.is_plus;
      cmd.step     = STEP_NONE;
      cmd.out_load = 1'b0;
      cmd.out_ok   = ok_ff;
      cmd.clear    = 1'b0;

      req_stall = (phase_ff != PH_PARSE);

      unique case (phase_ff)
         PH_PARSE: begin
            if (req_valid) begin
               if (stat.is_nul) begin
                  ok_in     = !failed_ff && (pos_ff == POS_END);
                  pos_in    = POS_Y0;
                  failed_in = 1'b0;
                  phase_in  = PH_C1;
               end else if (!failed_ff) begin
                  unique case (pos_ff)
                     POS_Y0, POS_Y1, POS_Y2, POS_Y3: begin
                        if (stat.is_digit) begin
                           cmd.acc = ACC_YEAR;
                           nxt     = pos_type'(5'(pos_ff) + 5'd1);
                        end else bad = 1'b1;
                     end
                     POS_AFTER_YEAR: begin
                        if (stat.is_dash) nxt = POS_MON0;
                        else if (stat.is_digit) begin
                           cmd.acc = ACC_MONTH;
                           nxt     = POS_MON1;
                        end else bad = 1'b1;
                     end
                     POS_MON0: begin
                        if (stat.is_digit) begin
                           cmd.acc = ACC_MONTH;
                           nxt     = POS_MON1;
                        end else bad = 1'b1;
                     end
                     POS_MON1: begin
                        if (stat.is_digit) begin
                           cmd.acc  = ACC_MONTH;
                           cmd.push = 1'b1;
                           nxt      = POS_AFTER_MON;
                        end else bad = 1'b1;
                     end
                     POS_AFTER_MON: begin
                        if (stat.is_dash) nxt = POS_DAY0;
                        else if (stat.is_digit) begin
                           cmd.acc = ACC_DAY;
                           nxt     = POS_DAY1;
                        end else bad = 1'b1;
                     end
                     POS_DAY0: begin
                        if (stat.is_digit) begin
                           cmd.acc = ACC_DAY;
                           nxt     = POS_DAY1;
                        end else bad = 1'b1;
                     end
                     POS_DAY1: begin
                        if (stat.is_digit) begin
                           cmd.acc  = ACC_DAY;
                           cmd.push = 1'b1;
                           nxt      = POS_T;
                        end else bad = 1'b1;
                     end
                     POS_T: begin
                        if (stat.is_t) nxt = POS_HR0;
                        else bad = 1'b1;
                     end
                     POS_HR0: begin
                        if (stat.is_digit) begin
                           cmd.acc = ACC_HOUR;
                           nxt     = POS_HR1;
                        end else bad = 1'b1;
                     end
                     POS_HR1: begin
                        if (stat.is_digit) begin
                           cmd.acc  = ACC_HOUR;
                           cmd.push = 1'b1;
                           nxt      = POS_AFTER_HR;
                        end else bad = 1'b1;
                     end
                     POS_AFTER_HR: begin
                        if (stat.is_colon) nxt = POS_MIN0;
                        else if (stat.is_digit) begin
                           cmd.acc = ACC_MINUTE;
                           nxt     = POS_MIN1;
                        end else bad = 1'b1;
                     end
                     POS_MIN0: begin
                        if (stat.is_digit) begin
                           cmd.acc = ACC_MINUTE;
                           nxt     = POS_MIN1;
                        end else bad = 1'b1;
                     end
                     POS_MIN1: begin
                        if (stat.is_digit) begin
                           cmd.acc  = ACC_MINUTE;
                           cmd.push = 1'b1;
                           nxt      = POS_AFTER_MIN;
                        end else bad = 1'b1;
                     end
                     // seconds are optional; the zone may follow directly
                     POS_AFTER_MIN, POS_AFTER_COLON, POS_ZONE: begin
                        priority if (stat.is_colon && (pos_ff == POS_AFTER_MIN)) begin
                           nxt = POS_AFTER_COLON;
                        end else if (stat.is_digit && (pos_ff != POS_ZONE)) begin
                           cmd.acc = ACC_SECOND;
                           nxt     = POS_SEC1;
                        end else if (stat.is_z) begin
                           nxt = POS_END;
                        end else if (stat.is_plus || stat.is_dash) begin
                           cmd.zone_set = 1'b1;
                           nxt          = POS_ZH0;
                        end else begin
                           bad = 1'b1;
                        end
                     end
                     POS_SEC1: begin
                        if (stat.is_digit) begin
                           cmd.acc  = ACC_SECOND;
                           cmd.push = 1'b1;
                           nxt      = POS_ZONE;
                        end else bad = 1'b1;
                     end
                     POS_ZH0: begin
                        if (stat.is_digit) begin
                           cmd.acc = ACC_ZH;
                           nxt     = POS_ZH1;
                        end else bad = 1'b1;
                     end
                     POS_ZH1: begin
                        if (stat.is_digit) begin
                           cmd.acc  = ACC_ZH;
                           cmd.push = 1'b1;
                           nxt      = POS_AFTER_ZH;
                        end else bad = 1'b1;
                     end
                     POS_AFTER_ZH: begin
                        if (stat.is_colon) nxt = POS_ZM0;
                        else if (stat.is_digit) begin
                           cmd.acc = ACC_ZM;
                           nxt     = POS_ZM1;
                        end else bad = 1'b1;
                     end
                     POS_ZM0: begin
                        if (stat.is_digit) begin
                           cmd.acc = ACC_ZM;
                           nxt     = POS_ZM1;
                        end else bad = 1'b1;
                     end
                     POS_ZM1: begin
                        if (stat.is_digit) begin
                           cmd.acc  = ACC_ZM;
                           cmd.push = 1'b1;
                           nxt      = POS_END;
                        end else bad = 1'b1;
                     end
                     // trailing text after the zone
                     default: bad = 1'b1;
                  endcase
                  if (bad) failed_in = 1'b1;
                  else pos_in = nxt;
               end
            end
         end
         PH_C1: begin cmd.step = STEP_1; phase_in = PH_C2;   end
         PH_C2: begin cmd.step = STEP_2; phase_in = PH_C3;   end
         PH_C3: begin cmd.step = STEP_3; phase_in = PH_C4;   end
         PH_C4: begin cmd.step = STEP_4; phase_in = PH_C5;   end
         PH_C5: begin cmd.step = STEP_5; phase_in = PH_C6;   end
         PH_C6: begin cmd.step = STEP_6; phase_in = PH_C7;   end
         PH_C7: begin cmd.step = STEP_7; phase_in = PH_C8;   end
         PH_C8: begin cmd.step = STEP_8; phase_in = PH_LOAD; end
         PH_LOAD: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               cmd.clear    = 1'b1;
               rsp_valid_in = 1'b1;
               phase_in     = PH_PARSE;
            end
         end
         default: phase_in = PH_PARSE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### tb/iso8601_timestamp_to_epoch_tb.sv
// ----------------------------------------------------------------------------
// iso8601_timestamp_to_epoch_tb
// Streams timestamp text into the converter one character per item and
// checks every ok/epoch result against a local parser and date-to-seconds
// model. Directed strings cover the grammar corners, then random strings
// (mostly well-formed, some damaged, some noise) run under bursty input
// and patterned output stalls.
// ----------------------------------------------------------------------------
module iso8601_timestamp_to_epoch_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import isots_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned RANDOM_CHARS = 1550;
   localparam int unsigned DRAIN_CYCLES = 30;

   typedef struct {
      logic                      ok;
      logic signed [EPOCH_W-1:0] secs;
   } epoch_result_type;

   class epoch_scoreboard;
      pos_type          pos;
      bit               failed;
      bit               zone_neg;
      int               yr, mon, dom, hr, mnt, sec, zone_hr, zone_mn;
      epoch_result_type awaited[$];
      int unsigned      mismatches;

      function new();
         mismatches = 0;
         restart();
      endfunction

      function void restart();
         pos = POS_Y0;
         failed = 0;
         zone_neg = 0;
         yr = 0; mon = 0; dom = 0; hr = 0; mnt = 0; sec = 0;
         zone_hr = 0; zone_mn = 0;
      endfunction

      // days since 1970-01-01 for a proleptic Gregorian date
      function longint civil_days(longint y, longint m, longint d);
         longint era, yoe, doy, doe;
         if (m <= 2) y = y - 1;
         era = (y >= 0 ? y : y - 399) / 400;
         yoe = y - era * 400;
         doy = (153 * (m + (m > 2 ? -3 : 9)) + 2) / 5 + d - 1;
         doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
         return era * 146097 + doe - 719468;
      endfunction

      function longint utc_seconds();
         longint months, y, m0, days, zone, secs;
         months = longint'(yr) * 12 + longint'(mon) - 1;
         // floor division so month 00 of year 0000 lands in December of -1
         y = months >= 0 ? months / 12 : -((11 - months) / 12);
         m0 = months - y * 12;
         days = civil_days(y, m0 + 1, 1) + longint'(dom) - 1;
         zone = longint'(zone_hr) * 3600 + longint'(zone_mn) * 60;
         secs = days * 86400 + longint'(hr) * 3600 + longint'(mnt) * 60
              + longint'(sec);
         return zone_neg ? secs + zone : secs - zone;
      endfunction

      function void take_char(logic [7:0] c);
         bit               dig, bad;
         int               d;
         pos_type          nxt;
         epoch_result_type r;
         longint           s;
         dig = (c >= CH_ZERO) && (c <= CH_NINE);
         d = dig ? int'(c - CH_ZERO) : 0;
         nxt = POS_END;
         bad = 0;
         if (c == CH_NUL) begin
            r.ok = !failed && (pos == POS_END);
            s = r.ok ? utc_seconds() : 0;
            r.secs = s[EPOCH_W-1:0];
            awaited.insert(awaited.size(), r);
            restart();
            return;
         end
         if (failed) return;
         case (pos)
            POS_Y0, POS_Y1, POS_Y2, POS_Y3: begin
               if (dig) begin
                  yr = yr * 10 + d;
                  nxt = pos_type'(pos + 5'd1);
               end else bad = 1;
            end
            POS_AFTER_YEAR: begin
               if (c == CH_DASH) nxt = POS_MON0;
               else if (dig) begin mon = d; nxt = POS_MON1; end
               else bad = 1;
            end
            POS_MON0: begin
               if (dig) begin mon = d; nxt = POS_MON1; end else bad = 1;
            end
            POS_MON1: begin
               if (dig) begin mon = mon * 10 + d; nxt = POS_AFTER_MON; end else bad = 1;
            end
            POS_AFTER_MON: begin
               if (c == CH_DASH) nxt = POS_DAY0;
               else if (dig) begin dom = d; nxt = POS_DAY1; end
               else bad = 1;
            end
            POS_DAY0: begin
               if (dig) begin dom = d; nxt = POS_DAY1; end else bad = 1;
            end
            POS_DAY1: begin
               if (dig) begin dom = dom * 10 + d; nxt = POS_T; end else bad = 1;
            end
            POS_T: begin
               if (c == CH_T) nxt = POS_HR0; else bad = 1;
            end
            POS_HR0: begin
               if (dig) begin hr = d; nxt = POS_HR1; end else bad = 1;
            end
            POS_HR1: begin
               if (dig) begin hr = hr * 10 + d; nxt = POS_AFTER_HR; end else bad = 1;
            end
            POS_AFTER_HR: begin
               if (c == CH_COLON) nxt = POS_MIN0;
               else if (dig) begin mnt = d; nxt = POS_MIN1; end
               else bad = 1;
            end
            POS_MIN0: begin
               if (dig) begin mnt = d; nxt = POS_MIN1; end else bad = 1;
            end
            POS_MIN1: begin
               if (dig) begin mnt = mnt * 10 + d; nxt = POS_AFTER_MIN; end else bad = 1;
            end
            POS_AFTER_MIN, POS_AFTER_COLON, POS_ZONE: begin
               if (c == CH_COLON && pos == POS_AFTER_MIN) nxt = POS_AFTER_COLON;
               else if (dig && pos != POS_ZONE) begin sec = d; nxt = POS_SEC1; end
               else if (c == CH_Z) nxt = POS_END;
               else if (c == CH_PLUS || c == CH_DASH) begin
                  zone_neg = (c == CH_DASH);
                  nxt = POS_ZH0;
               end else bad = 1;
            end
            POS_SEC1: begin
               if (dig) begin sec = sec * 10 + d; nxt = POS_ZONE; end else bad = 1;
            end
            POS_ZH0: begin
               if (dig) begin zone_hr = d; nxt = POS_ZH1; end else bad = 1;
            end
            POS_ZH1: begin
               if (dig) begin zone_hr = zone_hr * 10 + d; nxt = POS_AFTER_ZH; end
               else bad = 1;
            end
            POS_AFTER_ZH: begin
               if (c == CH_COLON) nxt = POS_ZM0;
               else if (dig) begin zone_mn = d; nxt = POS_ZM1; end
               else bad = 1;
            end
            POS_ZM0: begin
               if (dig) begin zone_mn = d; nxt = POS_ZM1; end else bad = 1;
            end
            POS_ZM1: begin
               if (dig) begin zone_mn = zone_mn * 10 + d; nxt = POS_END; end else bad = 1;
            end
            default: bad = 1;
         endcase
         if (bad) failed = 1;
         else pos = nxt;
      endfunction

      function void check_result(logic ok, logic signed [EPOCH_W-1:0] secs);
         epoch_result_type e;
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: ok=%0b secs=%0d", ok, secs);
            return;
         end
         e = awaited.pop_front();
         if (e.ok !== ok || e.secs !== secs) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected ok=%0b secs=%0d, got ok=%0b secs=%0d",
                        e.ok, e.secs, ok, secs);
         end
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [CH_W-1:0]           req_ch = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic                      rsp_ok;
   logic signed [EPOCH_W-1:0] rsp_epoch_seconds;

   epoch_scoreboard sb;
   int unsigned     cycles = 0;
   int unsigned     burst_left = 0;
   int unsigned     sent_chars = 0;
   logic [7:0]      stall_phase = '0;
   int unsigned     stall_mode = 0;
   byte unsigned    txt[$];

   iso8601_timestamp_to_epoch DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_ch            (req_ch),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_ok            (rsp_ok),
      .rsp_epoch_seconds (rsp_epoch_seconds)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // receiver stall pattern: free-flowing, coin-flip, or mostly stalled
   always @(posedge clock) begin
      stall_phase <= stall_phase + 8'd1;
      if (stall_phase == 8'd0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
         0:       rsp_stall <= 1'b0;
         1:       rsp_stall <= $urandom_range(0, 1);
         default: rsp_stall <= ($urandom_range(0, 7) != 0);
      endcase
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.take_char(req_ch);
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_ok, rsp_epoch_seconds);
      end
   end

   task automatic send_char(input logic [7:0] c);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(1, 12);
      end
      req_valid <= 1'b1;
      req_ch    <= c;
      do @(posedge clock); while (req_stall);
      burst_left--;
      sent_chars++;
   endtask

   task automatic send_text();
      foreach (txt[i]) send_char(txt[i]);
      send_char(CH_NUL);
      txt.delete();
   endtask

   task automatic append_char(input logic [7:0] c);
      txt.insert(txt.size(), c);
   endtask

   task automatic add_str(input string s);
      for (int i = 0; i < s.len(); i++) append_char(s[i]);
   endtask

   task automatic send_str(input string s);
      add_str(s);
      send_text();
   endtask

   task automatic add_num(input int unsigned v, input int unsigned n);
      int unsigned div;
      div = 1;
      repeat (n - 1) div = div * 10;
      repeat (n) begin
         append_char(8'(CH_ZERO + (v / div) % 10));
         div = div / 10;
      end
   endtask

   function automatic int unsigned pick(int unsigned lo, int unsigned hi, int unsigned top);
      return ($urandom_range(0, 3) != 0) ? $urandom_range(lo, hi) : $urandom_range(0, top);
   endfunction

   task automatic build_timestamp();
      int unsigned y;
      case ($urandom_range(0, 3))
         0:       y = $urandom_range(0, 9999);
         1: begin
            case ($urandom_range(0, 3))
               0:       y = 0;
               1:       y = 9999;
               2:       y = 1969;
               default: y = 1970;
            endcase
         end
         default: y = $urandom_range(1900, 2100);
      endcase
      add_num(y, 4);
      if ($urandom_range(0, 1)) add_str("-");
      add_num(pick(1, 12, 99), 2);
      if ($urandom_range(0, 1)) add_str("-");
      add_num(pick(1, 31, 99), 2);
      add_str("T");
      add_num(pick(0, 23, 99), 2);
      if ($urandom_range(0, 1)) add_str(":");
      add_num(pick(0, 59, 99), 2);
      case ($urandom_range(0, 3))
         0: ;
         1: add_str(":");
         2: begin add_str(":"); add_num(pick(0, 59, 99), 2); end
         default: add_num(pick(0, 59, 99), 2);
      endcase
      if ($urandom_range(0, 2) == 0) add_str("Z");
      else begin
         append_char($urandom_range(0, 1) ? CH_PLUS : CH_DASH);
         add_num(pick(0, 14, 99), 2);
         if ($urandom_range(0, 1)) add_str(":");
         add_num(($urandom_range(0, 3) != 0) ? 15 * $urandom_range(0, 3)
                                             : $urandom_range(0, 99), 2);
      end
   endtask

   initial begin
      int unsigned kind, n;
      sb = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send_str("");
      send_str("1970-01-01T00:00:00Z");
      send_str("19700101T0000Z");
      send_str("0000-00-00T00:00:00+99:99");
      send_str("9999-99-99T99:99:99-99:99");
      send_str("2024-02-29T12:34:56+0530");
      send_str("2000-03-01T00:00:Z");
      send_str("2000-03-01T00:005Z");
      send_str("2000-03-01T00:00Zjunk");
      send_str("2000-03-01T00:00:00");
      send_str("X000-01-01T00:00Z");
      send_str("1999-12-31T23:59:59-00:00");
      send_str("2000-1-01T00:00Z");
      send_str("1969-12-31T23:59:59Z");
      send_str("2000-03-01T00:00:00:00Z");
      send_str("\200\377");

      while (sent_chars < RANDOM_CHARS) begin
         kind = $urandom_range(0, 9);
         if (kind < 9) begin
            build_timestamp();
            // damaged strings: bad byte, cut short, or trailing text
            if (kind >= 7) begin
               case ($urandom_range(0, 2))
                  0: txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom_range(1, 255));
                  1: begin
                     n = $urandom_range(0, txt.size() - 1);
                     while (txt.size() > n) void'(txt.pop_back());
                  end
                  default: repeat ($urandom_range(1, 3)) append_char(8'($urandom_range(1, 255)));
               endcase
            end
         end else begin
            repeat ($urandom_range(1, 20)) append_char(8'($urandom_range(0, 255)));
         end
         send_text();
      end
      req_valid <= 1'b0;

      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+sv
sv/isots_pkg.sv
sv/isots_dp.sv
sv/isots_ctrl.sv
sv/iso8601_timestamp_to_epoch.sv
tb/iso8601_timestamp_to_epoch_tb.sv
